// ===== rtl/core/lzw_pkg.sv =====
package lzw_pkg;

	localparam int unsigned CODE_W        = 12;
	localparam int unsigned KEY_W         = 20;
	localparam int unsigned FIRST_LEARNED = 256;

	typedef struct packed {
		logic       last;
		logic [7:0] data;
	} lzw_item_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_CMP,
		ST_HI,
		ST_LO,
		ST_INS,
		ST_SWRD,
		ST_SWWR
	} lzw_state_t;

	typedef enum logic [1:0] {
		PH_MISS,
		PH_FIN,
		PH_PAD
	} lzw_phase_t;

endpackage

// ===== rtl/core/lzw_ram.sv =====
module lzw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/lzw_front.sv =====
module lzw_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	output logic              s_ready,
	input  lzw_pkg::lzw_item_t s_item,
	output logic              q_valid,
	input  logic              q_pop,
	output lzw_pkg::lzw_item_t q_item
);
	import lzw_pkg::*;

	lzw_item_t  buf_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign s_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = buf_q[rp_q];
	assign push    = s_valid && s_ready;
	assign pop     = q_pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= s_item;
		end
	end

endmodule

// ===== rtl/core/lzw_back.sv =====
module lzw_back #(
	parameter int unsigned DICT_ENTRIES       = 4096,
	parameter int unsigned MAX_STRING_LEN     = 50,
	parameter int unsigned STRING_STORE_BYTES = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  lzw_pkg::lzw_item_t q_item,
	output logic               m_valid,
	input  logic               m_ready,
	output logic [7:0]         m_byte,
	output logic               m_last
);
	import lzw_pkg::*;

	localparam int unsigned DBITS = $clog2(DICT_ENTRIES);
	localparam int unsigned NBITS = DBITS + 1;
	localparam int unsigned HBITS = DBITS + 1;
	localparam int unsigned HW    = 1 + KEY_W + DBITS;

	lzw_state_t        st_q, st_d;
	lzw_phase_t        ph_q;
	logic [CODE_W-1:0] cur_q;
	logic [6:0]        len_q;
	logic [NBITS-1:0]  next_q;
	logic [16:0]       store_q;
	logic              pend_q;
	logic [3:0]        nib_q;
	logic [7:0]        b_q;
	logic              last_q;
	logic [CODE_W-1:0] ecode_q;
	logic [HBITS-1:0]  slot_q;
	logic [HBITS-1:0]  clr_q;
	logic [NBITS-1:0]  sc_q;
	logic              ovalid_q;
	logic [7:0]        obyte_q;
	logic              olast_q;

	logic              out_free;
	logic              push;
	logic [7:0]        pbyte;
	logic              plast;
	logic              h_we;
	logic [HBITS-1:0]  h_waddr;
	logic [HW-1:0]     h_wdata;
	logic [HW-1:0]     h_rdata;
	logic              d_we;
	logic [HBITS-1:0]  d_rdata;
	logic [KEY_W-1:0]  key;
	logic [HBITS-1:0]  hsh;
	logic              hit_v;
	logic              hit_k;
	logic [CODE_W-1:0] hit_code;
	logic              ins_ok;
	logic [17:0]       store_sum;

	assign out_free  = !ovalid_q || m_ready;
	assign key       = {cur_q, b_q};
	assign hsh       = {q_item.data, {(HBITS-8){1'b0}}} ^ HBITS'(cur_q);
	assign hit_v     = h_rdata[HW-1];
	assign hit_k     = (h_rdata[HW-2:DBITS] == key);
	assign hit_code  = CODE_W'(h_rdata[DBITS-1:0]);
	assign store_sum = {1'b0, store_q} + 18'(len_q) + 18'd1;
	assign ins_ok    = (next_q < NBITS'(DICT_ENTRIES)) && (len_q < 7'(MAX_STRING_LEN))
		&& (store_sum < 18'(STRING_STORE_BYTES));
	assign m_valid   = ovalid_q;
	assign m_byte    = obyte_q;
	assign m_last    = olast_q;

	lzw_ram #(.WIDTH(HW), .DEPTH(1 << HBITS)) u_hash (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (slot_q),
		.rdata (h_rdata)
	);

	lzw_ram #(.WIDTH(HBITS), .DEPTH(DICT_ENTRIES)) u_dict (
		.clk   (clk),
		.we    (d_we),
		.waddr (next_q[DBITS-1:0]),
		.wdata (slot_q),
		.raddr (sc_q[DBITS-1:0]),
		.rdata (d_rdata)
	);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_CLEAR: begin
				if (&clr_q) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (q_valid) begin
					if (len_q == 7'd0) st_d = q_item.last ? ST_HI : ST_IDLE;
					else if (len_q < 7'(MAX_STRING_LEN)) st_d = ST_RD;
					else st_d = ST_HI;
				end
			end
			ST_RD: st_d = ST_CMP;
			ST_CMP: begin
				if (hit_v && hit_k) st_d = last_q ? ST_HI : ST_IDLE;
				else if (hit_v) st_d = ST_RD;
				else st_d = ST_HI;
			end
			ST_HI: begin
				if (out_free) begin
					if (pend_q) st_d = ST_LO;
					else if (ph_q == PH_MISS) st_d = ST_INS;
					else if (ecode_q[3:0] != 4'd0) st_d = ST_HI;
					else st_d = ST_SWRD;
				end
			end
			ST_LO: begin
				if (out_free) st_d = (ph_q == PH_MISS) ? ST_INS : ST_SWRD;
			end
			ST_INS: st_d = last_q ? ST_HI : ST_IDLE;
			ST_SWRD: st_d = (sc_q == next_q) ? ST_IDLE : ST_SWWR;
			ST_SWWR: st_d = ST_SWRD;
			default: st_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		q_pop   = 1'b0;
		push    = 1'b0;
		pbyte   = ecode_q[7:0];
		plast   = 1'b0;
		h_we    = 1'b0;
		h_waddr = slot_q;
		h_wdata = '0;
		d_we    = 1'b0;
		unique case (st_q)
			ST_CLEAR: begin
				h_we    = 1'b1;
				h_waddr = clr_q;
			end
			ST_IDLE: q_pop = q_valid;
			ST_HI: begin
				push = out_free;
				if (pend_q) begin
					pbyte = {nib_q, ecode_q[11:8]};
				end else begin
					pbyte = ecode_q[11:4];
					plast = (ph_q == PH_FIN) && (ecode_q[3:0] == 4'd0);
				end
			end
			ST_LO: begin
				push  = out_free;
				plast = (ph_q != PH_MISS);
			end
			ST_INS: begin
				h_we    = ins_ok;
				h_wdata = {1'b1, key, next_q[DBITS-1:0]};
				d_we    = ins_ok;
			end
			ST_SWWR: begin
				h_we    = 1'b1;
				h_waddr = d_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_CLEAR;
			ph_q     <= PH_MISS;
			cur_q    <= '0;
			len_q    <= '0;
			next_q   <= NBITS'(FIRST_LEARNED);
			store_q  <= 17'(FIRST_LEARNED);
			pend_q   <= 1'b0;
			nib_q    <= '0;
			b_q      <= '0;
			last_q   <= 1'b0;
			ecode_q  <= '0;
			slot_q   <= '0;
			clr_q    <= '0;
			sc_q     <= NBITS'(FIRST_LEARNED);
			ovalid_q <= 1'b0;
			obyte_q  <= '0;
			olast_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (push) begin
				ovalid_q <= 1'b1;
				obyte_q  <= pbyte;
				olast_q  <= plast;
			end else if (m_ready) begin
				ovalid_q <= 1'b0;
			end
			case (st_q)
				ST_CLEAR: clr_q <= clr_q + HBITS'(1);
				ST_IDLE: begin
					sc_q <= NBITS'(FIRST_LEARNED);
					if (q_valid) begin
						b_q    <= q_item.data;
						last_q <= q_item.last;
						if (len_q == 7'd0) begin
							cur_q   <= CODE_W'(q_item.data);
							len_q   <= 7'd1;
							ecode_q <= CODE_W'(q_item.data);
							ph_q    <= PH_FIN;
						end else if (len_q < 7'(MAX_STRING_LEN)) begin
							slot_q <= hsh;
						end else begin
							ecode_q <= cur_q;
							ph_q    <= PH_MISS;
						end
					end
				end
				ST_CMP: begin
					if (hit_v && hit_k) begin
						cur_q   <= hit_code;
						len_q   <= len_q + 7'd1;
						ecode_q <= hit_code;
						ph_q    <= PH_FIN;
					end else if (hit_v) begin
						slot_q <= slot_q + HBITS'(1);
					end else begin
						ecode_q <= cur_q;
						ph_q    <= PH_MISS;
					end
				end
				ST_HI: begin
					if (out_free) begin
						if (pend_q) begin
							pend_q <= 1'b0;
							nib_q  <= '0;
						end else begin
							pend_q <= 1'b1;
							nib_q  <= ecode_q[3:0];
							if (ph_q == PH_FIN && ecode_q[3:0] != 4'd0) begin
								ph_q    <= PH_PAD;
								ecode_q <= '0;
							end
						end
					end
				end
				ST_LO: begin
					if (out_free) begin
						pend_q <= 1'b0;
						nib_q  <= '0;
					end
				end
				ST_INS: begin
					if (ins_ok) begin
						next_q  <= next_q + NBITS'(1);
						store_q <= store_sum[16:0];
					end
					cur_q   <= CODE_W'(b_q);
					len_q   <= 7'd1;
					ecode_q <= CODE_W'(b_q);
					ph_q    <= PH_FIN;
				end
				ST_SWRD: begin
					if (sc_q == next_q) begin
						next_q  <= NBITS'(FIRST_LEARNED);
						store_q <= 17'(FIRST_LEARNED);
						cur_q   <= '0;
						len_q   <= '0;
						pend_q  <= 1'b0;
						nib_q   <= '0;
					end
				end
				ST_SWWR: sc_q <= sc_q + NBITS'(1);
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/lzw_encoder_12bit.sv =====
// LZW encoder with 12-bit codes packed big-endian, two codes to three bytes; one
// message ends with the request flagged by tlast, which flushes the final code and
// marks the last output byte. After reset the block clears its hash table, which holds twice
// DICT_ENTRIES entries (DICT_ENTRIES rounded up to a power of two), before it processes the
// first byte. The first byte of a message only starts the current string; a byte that
// extends the string goes through pop, hash-table read and compare; a byte that ends it
// also sends each code byte and then inserts the new entry. Each extra collision probe
// repeats the read and compare, and each output byte waits for m_axis_tready.
// After each message the learned entries are swept out, one read and one write per entry.
module lzw_encoder_12bit #(
	parameter int unsigned DICT_ENTRIES       = 4096,
	parameter int unsigned MAX_STRING_LEN     = 50,
	parameter int unsigned STRING_STORE_BYTES = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // out_byte
	output logic       m_axis_tlast
);
	import lzw_pkg::*;

	lzw_item_t s_item;
	lzw_item_t q_item;
	logic      q_valid;
	logic      q_pop;

	assign s_item.data = s_axis_tdata;
	assign s_item.last = s_axis_tlast;

	lzw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.s_item  (s_item),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_item  (q_item)
	);

	lzw_back #(
		.DICT_ENTRIES       (DICT_ENTRIES),
		.MAX_STRING_LEN     (MAX_STRING_LEN),
		.STRING_STORE_BYTES (STRING_STORE_BYTES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_item  (q_item),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_byte  (m_axis_tdata),
		.m_last  (m_axis_tlast)
	);

endmodule

// ===== test/lzw_encoder_12bit_tb.sv =====
module lzw_encoder_12bit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DICT_ENTRIES       = 4096;
	localparam int unsigned MAX_STRING_LEN     = 50;
	localparam int unsigned STRING_STORE_BYTES = 65536;
	localparam int unsigned N_RANDOM           = 160;
	localparam int unsigned CYCLE_LIMIT        = 1000000;

	typedef struct packed {
		logic       last;
		logic [7:0] data;
	} out_byte_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
		int         n_fixed;
		logic [7:0] fixed[3];
	} row_t;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;

	lzw_encoder_12bit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	logic [19:0] dict_keys[DICT_ENTRIES - 256];
	int unsigned next_code;
	int unsigned store_used;
	logic [11:0] cur_code;
	int unsigned cur_len;
	bit          nib_pending;
	logic [3:0]  nib_held;

	out_byte_t   expected_bytes[$];
	int          errors;
	bit          quiet_out;
	bit          quiet_in;
	longint      cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic clear_message();
		next_code   = 256;
		store_used  = 256;
		cur_code    = '0;
		cur_len     = 0;
		nib_pending = 0;
		nib_held    = '0;
	endtask

	task automatic push_code(input logic [11:0] code);
		if (nib_pending) begin
			expected_bytes.push_back('{1'b0, {nib_held, code[11:8]}});
			expected_bytes.push_back('{1'b0, code[7:0]});
			nib_pending = 0;
			nib_held    = '0;
		end else begin
			expected_bytes.push_back('{1'b0, code[11:4]});
			nib_held    = code[3:0];
			nib_pending = 1;
		end
	endtask

	task automatic encode_byte(input logic [7:0] b, input logic last);
		logic [19:0] key;
		int          hit;
		hit = -1;
		if (cur_len == 0) begin
			cur_code = {4'h0, b};
			cur_len  = 1;
		end else begin
			key = {cur_code, b};
			if (cur_len < MAX_STRING_LEN)
				for (int i = 0; i + 256 < next_code; i++)
					if (dict_keys[i] == key) begin
						hit = i + 256;
						break;
					end
			if (hit >= 0) begin
				cur_code = hit[11:0];
				cur_len++;
			end else begin
				push_code(cur_code);
				if (next_code < DICT_ENTRIES && cur_len < MAX_STRING_LEN &&
						store_used + cur_len + 1 < STRING_STORE_BYTES) begin
					dict_keys[next_code - 256] = key;
					next_code++;
					store_used += cur_len + 1;
				end
				cur_code = {4'h0, b};
				cur_len  = 1;
			end
		end
		if (last) begin
			push_code(cur_code);
			if (nib_pending && nib_held != 0)
				push_code(12'h000);
			expected_bytes[$].last = 1'b1;
			clear_message();
		end
	endtask

	task automatic send_request(input logic [7:0] b, input logic last);
		int gap;
		if (!quiet_in && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		encode_byte(b, last);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		out_byte_t exp_b;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("== FAIL ==");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t unexpected output: expected none, actual %02h last %b",
					$time, m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				exp_b = expected_bytes.pop_front();
				if (m_axis_tdata !== exp_b.data || m_axis_tlast !== exp_b.last) begin
					$display("%0t mismatch: expected %02h last %b, actual %02h last %b",
						$time, exp_b.data, exp_b.last, m_axis_tdata, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!quiet_out && $urandom_range(0, 9) == 0) begin
			m_axis_tready <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		row_t        rows[$];
		int          msg_len;
		int          n_sent;
		logic [7:0]  alpha;
		logic [7:0]  b;
		out_byte_t   e;

		errors        = 0;
		cycles        = 0;
		quiet_out     = 0;
		quiet_in      = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		clear_message();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// single byte messages: code 0x0FF, pad code 0x000 -> 0F F0 00;
		// code 0x000 -> 00 (nibble 0 dropped)
		rows.push_back('{8'hFF, 1'b1, 3, '{8'h0F, 8'hF0, 8'h00}});
		rows.push_back('{8'h00, 1'b1, 1, '{8'h00, 8'h00, 8'h00}});
		// two codes 0x041, 0x042 -> 04 10 42
		rows.push_back('{8'h41, 1'b0, 0, '{8'h00, 8'h00, 8'h00}});
		rows.push_back('{8'h42, 1'b1, 3, '{8'h04, 8'h10, 8'h42}});
		// repeats build learned entries
		for (int i = 0; i < 12; i++)
			rows.push_back('{8'hAA, i == 11, -1, '{8'h00, 8'h00, 8'h00}});
		rows.push_back('{8'h55, 1'b0, -1, '{8'h00, 8'h00, 8'h00}});
		rows.push_back('{8'h80, 1'b0, -1, '{8'h00, 8'h00, 8'h00}});
		rows.push_back('{8'h55, 1'b0, -1, '{8'h00, 8'h00, 8'h00}});
		rows.push_back('{8'h80, 1'b0, -1, '{8'h00, 8'h00, 8'h00}});
		rows.push_back('{8'h01, 1'b1, -1, '{8'h00, 8'h00, 8'h00}});

		foreach (rows[i]) begin
			send_request(rows[i].data, rows[i].last);
			if (rows[i].n_fixed >= 0 && rows[i].last) begin
				if (expected_bytes.size() < rows[i].n_fixed) begin
					$display("%0t directed row %0d: expected %0d bytes, predicted %0d",
						$time, i, rows[i].n_fixed, expected_bytes.size());
					errors++;
				end
				for (int k = 0; k < rows[i].n_fixed && k < expected_bytes.size(); k++) begin
					e = expected_bytes[expected_bytes.size() - rows[i].n_fixed + k];
					if (e.data !== rows[i].fixed[k]) begin
						$display("%0t directed row %0d byte %0d: expected %02h, actual %02h",
							$time, i, k, rows[i].fixed[k], e.data);
						errors++;
					end
				end
			end
		end

		// long run of one byte grows learned strings
		for (int i = 0; i < 40; i++)
			send_request(8'h33, i == 39);

		drain();

		n_sent = 0;
		while (n_sent < N_RANDOM) begin
			if (n_sent > N_RANDOM * 3 / 4) begin
				quiet_in  = 1;
				quiet_out = 1;
			end
			msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) :
				$urandom_range(4, 40);
			alpha = ($urandom_range(0, 2) == 0) ? 8'd255 : 8'($urandom_range(1, 4));
			for (int i = 0; i < msg_len && n_sent < N_RANDOM; i++) begin
				b = (alpha == 8'd255) ? 8'($urandom) : 8'($urandom_range(0, alpha));
				if ($urandom_range(0, 1) == 0)
					b = b ^ 8'hF0;
				send_request(b, i == msg_len - 1 || n_sent == N_RANDOM - 1);
				n_sent++;
			end
			if ($urandom_range(0, 9) == 0)
				drain();
		end

		drain();
		repeat (20000) @(negedge clk);
		if (errors == 0 && expected_bytes.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/lzw_pkg.sv
rtl/core/lzw_ram.sv
rtl/core/lzw_front.sv
rtl/core/lzw_back.sv
rtl/core/lzw_encoder_12bit.sv
test/lzw_encoder_12bit_tb.sv
